@@ src/assert_macros.svh @@
// Assertion helpers used by the pressure_sample_guard_core RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/psg_pkg.sv @@
package psg_pkg;

  // Input word
  typedef struct packed {
    logic              bus_error;
    logic signed [15:0] raw_sample;
  } psg_in_t;

  // Result word
  typedef struct packed {
    logic signed [16:0] pressure;
    logic [1:0]         sample_status;
    logic               reinit_request;
  } psg_out_t;

  // Configuration registers
  typedef struct packed {
    logic signed [15:0] zero_offset;
    logic signed [16:0] min_pressure;
    logic signed [16:0] max_pressure;
    logic [16:0]        max_jump;
    logic [8:0]         blend_weight;
    logic [7:0]         error_limit;
  } psg_cfg_t;

  // Filter state carried from one word to the next
  typedef struct packed {
    logic signed [16:0] held_pressure;
    logic [7:0]         error_run;
  } psg_state_t;

  // Status codes
  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_BLENDED  = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_ERROR    = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_ZERO_OFFSET  = 3'd0;
  localparam logic [2:0] REG_MIN_PRESSURE = 3'd1;
  localparam logic [2:0] REG_MAX_PRESSURE = 3'd2;
  localparam logic [2:0] REG_MAX_JUMP     = 3'd3;
  localparam logic [2:0] REG_BLEND_WEIGHT = 3'd4;
  localparam logic [2:0] REG_ERROR_LIMIT  = 3'd5;

  // Register reset values
  localparam logic signed [15:0] ZERO_OFFSET_RST  = 16'sd3000;
  localparam logic signed [16:0] MIN_PRESSURE_RST = -17'sd1024;
  localparam logic signed [16:0] MAX_PRESSURE_RST = 17'sd24576;
  localparam logic [16:0]        MAX_JUMP_RST     = 17'd3072;
  localparam logic [8:0]         BLEND_WEIGHT_RST = 9'd77;
  localparam logic [7:0]         ERROR_LIMIT_RST  = 8'd5;

  // Full-weight blend takes the new sample whole
  localparam logic [8:0] BLEND_FULL = 9'd256;

endpackage

@@ src/psg_filter.sv @@
module psg_filter (
  input  logic                bus_error,
  input  logic signed [16:0]  pressure_in,
  input  psg_pkg::psg_cfg_t   cfg,
  input  psg_pkg::psg_state_t state,
  output psg_pkg::psg_state_t state_nxt,
  output psg_pkg::psg_out_t   result
);
  import psg_pkg::*;

  logic signed [17:0] diff;
  logic [17:0]        mag;
  logic [8:0]         w_sat;
  logic signed [26:0] prod;
  logic signed [18:0] blend;
  logic [8:0]         run_inc;
  logic               in_range;
  logic               jump_big;

  // Distance from the held value and blend toward it
  always_comb begin
    diff     = 18'(pressure_in) - 18'(state.held_pressure);
    mag      = diff[17] ? 18'(-diff) : 18'(diff);
    w_sat    = (cfg.blend_weight > BLEND_FULL) ? BLEND_FULL : cfg.blend_weight;
    prod     = 27'(diff) * 27'($signed({1'b0, w_sat}));
    blend    = 19'(state.held_pressure) + 19'(prod >>> 8);
    in_range = !(pressure_in < cfg.min_pressure) && !(pressure_in > cfg.max_pressure);
    jump_big = mag > {1'b0, cfg.max_jump};
    run_inc  = {1'b0, state.error_run} + 9'd1;
  end

  // Select the result and the next state
  always_comb begin
    state_nxt             = state;
    result.pressure       = state.held_pressure;
    result.sample_status  = ST_ERROR;
    result.reinit_request = 1'b0;
    if (bus_error) begin
      if (run_inc > {1'b0, cfg.error_limit}) begin
        state_nxt.error_run     = '0;
        state_nxt.held_pressure = '0;
        result.pressure         = '0;
        result.reinit_request   = 1'b1;
      end else begin
        state_nxt.error_run = run_inc[7:0];
      end
    end else begin
      state_nxt.error_run = '0;
      if (!in_range) begin
        result.sample_status = ST_RANGE;
      end else if (jump_big) begin
        result.pressure         = blend[16:0];
        result.sample_status    = ST_BLENDED;
        state_nxt.held_pressure = blend[16:0];
      end else begin
        result.pressure         = pressure_in;
        result.sample_status    = ST_ACCEPTED;
        state_nxt.held_pressure = pressure_in;
      end
    end
  end

endmodule

@@ src/pressure_sample_guard_core.sv @@
// Pressure sample guard.
// Input channel (in_valid / in_stall / in_data): one word per converter read,
// carrying the bus-error flag and the signed raw sample.
// Result channel (out_valid / out_stall / out_data): exactly one word per
// input word, in order: filtered pressure in counts of 1/2048 bar, status
// (accepted, blended, out of range held, error held) and a reinit request.
// Configuration: APB-style port, registers at byte address 4*index; write
// only while no word is in flight.
// Path: an accepted word moves into the input register and is filtered into
// the output register once that register is empty or its result is taken,
// which raises out_valid; a stalled result can hold it in the input register.
// Throughput: one word per cycle while the result side does not stall; the
// held-pressure and error-run state is updated by the filter stage in the same cycle that it reads it.
// Reset: registers return to their defaults, held pressure and error run
// clear, both pipeline registers empty.
// Stall: a stalled result holds; the input register still fills, then
// in_stall rises until the result is taken.
`include "assert_macros.svh"

module pressure_sample_guard_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  psg_pkg::psg_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output psg_pkg::psg_out_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import psg_pkg::*;

  psg_cfg_t           cfg_r;
  psg_state_t         state_r;
  psg_state_t         state_nxt;
  psg_out_t           filt_out;
  psg_out_t           out_data_r;
  logic               out_valid_r;
  logic               s1_valid_r;
  logic               s1_err_r;
  logic signed [16:0] s1_pressure_r;
  logic [2:0]         reg_idx;
  logic               cfg_write;
  logic               in_fire;
  logic               s1_fire;

  // Handshake
  assign s1_fire   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && out_valid_r && out_stall;
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Register port decode
  assign pready    = 1'b1;
  assign reg_idx   = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zero_offset  <= ZERO_OFFSET_RST;
      cfg_r.min_pressure <= MIN_PRESSURE_RST;
      cfg_r.max_pressure <= MAX_PRESSURE_RST;
      cfg_r.max_jump     <= MAX_JUMP_RST;
      cfg_r.blend_weight <= BLEND_WEIGHT_RST;
      cfg_r.error_limit  <= ERROR_LIMIT_RST;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_ZERO_OFFSET:  cfg_r.zero_offset  <= pwdata[15:0];
        REG_MIN_PRESSURE: cfg_r.min_pressure <= pwdata[16:0];
        REG_MAX_PRESSURE: cfg_r.max_pressure <= pwdata[16:0];
        REG_MAX_JUMP:     cfg_r.max_jump     <= pwdata[16:0];
        REG_BLEND_WEIGHT: cfg_r.blend_weight <= pwdata[8:0];
        REG_ERROR_LIMIT:  cfg_r.error_limit  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    unique case (reg_idx)
      REG_ZERO_OFFSET:  prdata = 32'(cfg_r.zero_offset);
      REG_MIN_PRESSURE: prdata = 32'(cfg_r.min_pressure);
      REG_MAX_PRESSURE: prdata = 32'(cfg_r.max_pressure);
      REG_MAX_JUMP:     prdata = {15'd0, cfg_r.max_jump};
      REG_BLEND_WEIGHT: prdata = {23'd0, cfg_r.blend_weight};
      REG_ERROR_LIMIT:  prdata = {24'd0, cfg_r.error_limit};
      default:          prdata = '0;
    endcase
  end

  // Input register: take the word and remove the zero offset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire || (s1_valid_r && !s1_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_err_r      <= in_data.bus_error;
      s1_pressure_r <= 17'(in_data.raw_sample) - 17'(cfg_r.zero_offset);
    end
  end

  // Filter stage
  psg_filter u_filter (
    .bus_error   (s1_err_r),
    .pressure_in (s1_pressure_r),
    .cfg         (cfg_r),
    .state       (state_r),
    .state_nxt   (state_nxt),
    .result      (filt_out)
  );

  // Advance state as the word leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_fire) begin
      state_r <= state_nxt;
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_fire || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= filt_out;
    end
  end

  // Checks
  `ASSERT_SAME(a_reinit_clears, out_valid_r && out_data_r.reinit_request,
    out_data_r.sample_status == ST_ERROR && out_data_r.pressure == '0,
    "reinit without cleared error result")
  `ASSERT_NEXT(a_state_hold, !s1_fire, $stable(state_r), "filter state moved without a word")
  `ASSERT_NEXT(a_run_clear, s1_fire && !s1_err_r, state_r.error_run == '0,
    "error run kept after a clean word")

endmodule

@@ test/pressure_guard_checker.sv @@
`timescale 1ns / 100ps

// Watches the sample and result channels and the register port, predicts
// each result word from the accepted sample words and compares in order.
module pressure_guard_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  psg_pkg::psg_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  psg_pkg::psg_out_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                pending_words,
  output int                fail_count
);
  import psg_pkg::*;

  localparam int MAX_REPORTS = 10;

  // Predictor copy of the registers and the filter state
  psg_cfg_t           cfg;
  logic signed [16:0] held;
  logic [7:0]         run_len;

  psg_out_t due_words[$];
  psg_out_t want;
  int       faults = 0;

  // Filter one sample word and advance the predicted state
  function automatic psg_out_t filter_sample(psg_in_t w);
    psg_out_t r;
    int       next_run;
    int       p;
    int       diff;
    int       mag;
    int       wgt;
    longint   blend_sum;
    r = '0;
    if (w.bus_error) begin
      next_run = int'(run_len) + 1;
      // Run past the limit: request reinit and drop the held value
      if (next_run > int'(cfg.error_limit)) begin
        r.reinit_request = 1'b1;
        run_len = '0;
        held = '0;
      end else begin
        run_len = next_run[7:0];
      end
      r.pressure = held;
      r.sample_status = ST_ERROR;
    end else begin
      p = $signed(w.raw_sample) - $signed(cfg.zero_offset);
      run_len = '0;
      if (p < $signed(cfg.min_pressure) || p > $signed(cfg.max_pressure)) begin
        r.pressure = held;
        r.sample_status = ST_RANGE;
      end else begin
        diff = p - $signed(held);
        mag = (diff < 0) ? -diff : diff;
        if (mag > int'(cfg.max_jump)) begin
          // Weight saturates at full; arithmetic shift floors the blend
          wgt = (cfg.blend_weight > BLEND_FULL) ? int'(BLEND_FULL) : int'(cfg.blend_weight);
          blend_sum = longint'($signed(held)) * (int'(BLEND_FULL) - wgt)
                    + longint'(p) * wgt;
          r.pressure = 17'(blend_sum >>> 8);
          r.sample_status = ST_BLENDED;
        end else begin
          r.pressure = p[16:0];
          r.sample_status = ST_ACCEPTED;
        end
        held = r.pressure;
      end
    end
    return r;
  endfunction

  function automatic void note_fault(string what, psg_out_t exp_w, psg_out_t got_w);
    faults++;
    if (faults <= MAX_REPORTS)
      $display("%0t: %s: expected p=%0d st=%0d ri=%0d, got p=%0d st=%0d ri=%0d",
               $realtime, what, $signed(exp_w.pressure), exp_w.sample_status,
               exp_w.reinit_request, $signed(got_w.pressure), got_w.sample_status,
               got_w.reinit_request);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      cfg.zero_offset = ZERO_OFFSET_RST;
      cfg.min_pressure = MIN_PRESSURE_RST;
      cfg.max_pressure = MAX_PRESSURE_RST;
      cfg.max_jump = MAX_JUMP_RST;
      cfg.blend_weight = BLEND_WEIGHT_RST;
      cfg.error_limit = ERROR_LIMIT_RST;
      held = '0;
      run_len = '0;
      due_words.delete();
    end else begin
      // Track register writes; spare addresses are ignored
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_ZERO_OFFSET:  cfg.zero_offset = pwdata[15:0];
          REG_MIN_PRESSURE: cfg.min_pressure = pwdata[16:0];
          REG_MAX_PRESSURE: cfg.max_pressure = pwdata[16:0];
          REG_MAX_JUMP:     cfg.max_jump = pwdata[16:0];
          REG_BLEND_WEIGHT: cfg.blend_weight = pwdata[8:0];
          REG_ERROR_LIMIT:  cfg.error_limit = pwdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        due_words.push_back(filter_sample(in_data));
      // Compare each taken result word with the oldest one due
      if (out_valid && !out_stall) begin
        if (due_words.size() == 0) begin
          note_fault("result word with none due", '0, out_data);
        end else begin
          want = due_words.pop_front();
          if (want.pressure !== out_data.pressure
              || want.sample_status !== out_data.sample_status
              || want.reinit_request !== out_data.reinit_request)
            note_fault("result word mismatch", want, out_data);
        end
      end
    end
    pending_words <= due_words.size();
    fail_count <= faults;
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import psg_pkg::*;

  localparam int IDLE_PCT       = 27;
  localparam int LONG_HOLD      = 60;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 8;

  // Addresses past the register list
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  psg_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  psg_out_t    out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int pending_words;
  int fail_count;

  // Stimulus knobs shared with the receiver
  bit idle_on = 1'b1;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet = 0;

  // Stimulus-side view of the settings, used only to shape samples
  int cur_off = 3000;
  int cur_min = -1024;
  int cur_max = 24576;
  int cur_jump = 3072;
  int cur_limit = 5;
  int last_p = 0;
  int burst_left = 0;

  pressure_sample_guard_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  pressure_guard_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .pending_words(pending_words),
    .fail_count   (fail_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Offer one word, with an optional gap, and hold until it is taken
  task automatic offer(input logic err, input int raw);
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_valid <= 1'b1;
    in_data <= '{bus_error: err, raw_sample: raw[15:0]};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop sending and wait until every result word is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [31:0] off, lo, hi, jump, wgt, lim);
    write_reg(REG_ZERO_OFFSET, off);
    write_reg(REG_MIN_PRESSURE, lo);
    write_reg(REG_MAX_PRESSURE, hi);
    write_reg(REG_MAX_JUMP, jump);
    write_reg(REG_BLEND_WEIGHT, wgt);
    write_reg(REG_ERROR_LIMIT, lim);
    cur_off = $signed(off[15:0]);
    cur_min = $signed(lo[16:0]);
    cur_max = $signed(hi[16:0]);
    cur_jump = int'(jump[16:0]);
    cur_limit = int'(lim[7:0]);
  endtask

  // Mostly in-range samples or samples near the last one, error bursts sized to the
  // limit, and some raw noise and extremes
  task automatic offer_random();
    int   sel;
    int   p;
    int   d;
    int   raw;
    logic err;
    err = 1'b0;
    if (burst_left > 0) begin
      burst_left--;
      err = 1'b1;
    end else if ($urandom_range(99) < 8) begin
      burst_left = $urandom_range((cur_limit + 1 < 12) ? cur_limit + 1 : 12);
      err = 1'b1;
    end
    sel = $urandom_range(99);
    if (sel < 45) begin
      if (cur_max >= cur_min) p = cur_min + int'($urandom_range(cur_max - cur_min));
      else p = int'($urandom_range(131071)) - 65536;
      raw = p + cur_off;
    end else if (sel < 75) begin
      d = (cur_jump < 40000) ? cur_jump + 16 : 40000;
      p = last_p + int'($urandom_range(2 * d)) - d;
      raw = p + cur_off;
    end else if (sel < 90) begin
      raw = $signed($urandom() & 32'hffff) - 32768;
    end else begin
      case ($urandom_range(3))
        0: raw = -32768;
        1: raw = 32767;
        2: raw = 0;
        default: raw = -1;
      endcase
    end
    if (raw < -32768) raw = -32768;
    if (raw > 32767) raw = 32767;
    if (!err) last_p = raw - cur_off;
    offer(err, raw);
  endtask

  task automatic run_phase(input int n, input bit long_hold);
    if (long_hold) hold_asks++;
    repeat (n) offer_random();
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at reset settings: zero, range edges, extremes
    offer(1'b0, 3000);
    offer(1'b0, 32767);
    offer(1'b0, -32768);
    offer(1'b0, 3000 + 24576);
    offer(1'b0, 3000 - 1024);
    // Error run past the limit of five requests a reinit
    repeat (6) offer(1'b1, -1);
    offer(1'b0, 3100);
    drain();

    // Spare addresses must not disturb the settings
    write_reg(REG_SPARE_LO, 32'hffff_ffff);
    write_reg(REG_SPARE_HI, 32'h0000_0001);

    // Lower the limit below a run already in progress
    write_reg(REG_ERROR_LIMIT, 32'd10);
    repeat (4) offer(1'b1, 0);
    drain();
    write_reg(REG_ERROR_LIMIT, 32'd2);
    offer(1'b1, 0);
    offer(1'b0, 3000);
    drain();
    write_reg(REG_ERROR_LIMIT, 32'd5);
    cur_limit = 5;

    run_phase(80, 1'b0);

    // Widest range, no jump tolerance, full weight, no errors tolerated
    apply_setting(-32768, -65536, 65535, 0, 256, 0);
    idle_on = 1'b0;
    run_phase(80, 1'b0);
    idle_on = 1'b1;

    // Largest offset and jump, zero weight, largest limit
    apply_setting(32767, -65536, 65535, 131071, 0, 255);
    run_phase(80, 1'b1);

    // Minimum above maximum, weight above full
    apply_setting(0, 1000, -1000, 100, 300, 3);
    run_phase(60, 1'b0);

    apply_setting(-200, -2000, 20000, 500, 128, 2);
    run_phase(80, 1'b0);

    apply_setting($urandom(), -int'($urandom_range(40000)), $urandom_range(40000),
                  $urandom_range(8000), $urandom_range(511), $urandom_range(8));
    run_phase(80, 1'b1);

    apply_setting($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    run_phase(80, 1'b0);

    apply_setting(3000, -1024, 24576, 3072, 511, 1);
    run_phase(80, 1'b0);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_words == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
